// ===== sv/rps_pkg.sv =====
// Shared types, constants and helpers of the row page Shell sorter.
`default_nettype none
package rps_pkg;

  localparam int unsigned KEY_SLOTS = 8;
  localparam int unsigned KEY_BITS  = 32;
  localparam logic [3:0]  DIMS_RESET = 4'd4;

  typedef logic [KEY_SLOTS-1:0][KEY_BITS-1:0] keys_t;

  typedef struct packed {
    logic [63:0] row_value;
    logic [31:0] key_0;
    logic [31:0] key_1;
    logic [31:0] key_2;
    logic [31:0] key_3;
    logic [31:0] key_4;
    logic [31:0] key_5;
    logic [31:0] key_6;
    logic [31:0] key_7;
    logic        is_marked;
    logic        is_deleted;
    logic        last_row;
  } in_item_t;

  typedef struct packed {
    logic [63:0] out_value;
    logic [31:0] out_key_0;
    logic [31:0] out_key_1;
    logic [31:0] out_key_2;
    logic [31:0] out_key_3;
    logic [31:0] out_key_4;
    logic [31:0] out_key_5;
    logic [31:0] out_key_6;
    logic [31:0] out_key_7;
    logic        out_marked;
    logic [2:0]  change_dim;
    logic        last_out;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_GAP,
    ST_PASS,
    ST_SAVE_RD,
    ST_SAVE_WT,
    ST_TEST,
    ST_CMP,
    ST_PUT,
    ST_EMIT_RD,
    ST_EMIT_WT,
    ST_EMIT_HOLD
  } state_t;

  // key words of an input item as an array
  function automatic keys_t in_keys(input in_item_t it);
    keys_t k;
    k[0] = it.key_0;
    k[1] = it.key_1;
    k[2] = it.key_2;
    k[3] = it.key_3;
    k[4] = it.key_4;
    k[5] = it.key_5;
    k[6] = it.key_6;
    k[7] = it.key_7;
    return k;
  endfunction

endpackage
`default_nettype wire

// ===== sv/rps_row_mem.sv =====
// Row store: one write port, one read port, registered read data.
`default_nettype none
module rps_row_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 322,
  parameter int unsigned AW    = 6
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== sv/rps_row_cmp.sv =====
// Row order test: is the held row strictly before a stored row.
`default_nettype none
module rps_row_cmp #(
  parameter int unsigned MAX_DIMS = 8
) (
  input  wire logic [MAX_DIMS-1:0][31:0] held_keys,
  input  wire logic                      held_del,
  input  wire logic [MAX_DIMS-1:0][31:0] row_keys,
  input  wire logic                      row_del,
  input  wire logic [3:0]                dims,
  output logic                           held_first
);

  logic [MAX_DIMS-1:0][31:0] a_m;
  logic [MAX_DIMS-1:0][31:0] b_m;

  // unused dimensions compare as equal; highest dimension is most significant
  always_comb begin
    for (int d = 0; d < MAX_DIMS; d++) begin
      a_m[d] = (4'(d) < dims) ? held_keys[d] : 32'd0;
      b_m[d] = (4'(d) < dims) ? row_keys[d]  : 32'd0;
    end
    if (held_del) begin
      held_first = 1'b0;
    end else if (row_del) begin
      held_first = 1'b1;
    end else begin
      held_first = (a_m < b_m);
    end
  end

endmodule
`default_nettype wire

// ===== sv/row_page_shell_sorter.sv =====
// Top level: row load, Shell sort sequencer over the row store, row emission.
// Rows of a page are taken one per cycle and written to a single-port-pair row
// store. The row with last_row set ends the page: the block then stops taking
// items, Shell sorts the held rows in place (Knuth gaps) through the store's one
// read and one write port, and emits the live rows in key order, one at a time,
// each read, registered and held until taken. Each insertion runs through a pass
// check, a read of the row to insert and its read wait, the first read and
// compare below it, and the final write; each row moved adds a read, then a
// compare and move. Before the passes the starting gap is grown. Rows beyond
// MAX_ROWS are dropped, deleted rows are not emitted, and a page without live
// rows gives no results.
`default_nettype none
module row_page_shell_sorter #(
  parameter int unsigned MAX_ROWS   = 64,
  parameter int unsigned MAX_DIMS   = 8,
  parameter int unsigned VALUE_BITS = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire rps_pkg::in_item_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output rps_pkg::out_item_t       out_data,
  input  wire logic                cfg_we,
  input  wire logic [3:0]          cfg_data
);

  localparam int unsigned AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CW = $clog2(MAX_ROWS + 1);
  localparam int unsigned IW = CW + 1;
  localparam int unsigned KW = MAX_DIMS * 32;
  localparam int unsigned RW = KW + VALUE_BITS + 2;

  rps_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] live_r, live_nxt;
  logic [CW-1:0] h_r, h_nxt;
  logic [IW-1:0] i_r, i_nxt;
  logic [IW-1:0] j_r, j_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [3:0]    cfg_dims_r;
  logic [3:0]    dims_r, dims_nxt;
  logic [RW-1:0] held_r, held_nxt;
  logic [MAX_DIMS-1:0][31:0] prev_keys_r, prev_keys_nxt;
  rps_pkg::out_item_t out_r, out_nxt;
  logic out_valid_r, out_valid_nxt;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [RW-1:0] mem_wdata, mem_rdata;

  logic [MAX_DIMS-1:0][31:0] held_keys, rd_keys, in_keys_p;
  logic [VALUE_BITS-1:0]     rd_value;
  logic                      held_first;
  logic [3:0]                dims_clamp;
  logic [CW-1:0]             h_div3;
  rps_pkg::keys_t            in_all;

  // row store
  rps_row_mem #(.DEPTH(MAX_ROWS), .WIDTH(RW), .AW(AW)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .re(mem_re), .raddr(mem_raddr), .rdata(mem_rdata)
  );

  // order test between the held row and the row just read
  rps_row_cmp #(.MAX_DIMS(MAX_DIMS)) u_cmp (
    .held_keys(held_keys), .held_del(held_r[1]),
    .row_keys(rd_keys), .row_del(mem_rdata[1]),
    .dims(dims_r), .held_first(held_first)
  );

  // row field views
  always_comb begin
    in_all = rps_pkg::in_keys(in_data);
    for (int d = 0; d < MAX_DIMS; d++) begin
      in_keys_p[d] = in_all[d];
    end
    held_keys = held_r[RW-1 -: KW];
    rd_keys   = mem_rdata[RW-1 -: KW];
    rd_value  = mem_rdata[2 +: VALUE_BITS];
  end

  // dims in force, clamped to 1..MAX_DIMS
  always_comb begin
    if (cfg_dims_r == 4'd0) begin
      dims_clamp = 4'd1;
    end else if (cfg_dims_r > 4'(MAX_DIMS)) begin
      dims_clamp = 4'(MAX_DIMS);
    end else begin
      dims_clamp = cfg_dims_r;
    end
  end

  // h/3 by reciprocal, exact for h below 256
  assign h_div3 = CW'((16'(h_r) * 16'd171) >> 9);

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_dims_r <= rps_pkg::DIMS_RESET;
    end else if (cfg_we) begin
      cfg_dims_r <= cfg_data;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rps_pkg::ST_LOAD;
      cnt_r       <= '0;
      live_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      live_r      <= live_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    h_r         <= h_nxt;
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    k_r         <= k_nxt;
    dims_r      <= dims_nxt;
    held_r      <= held_nxt;
    prev_keys_r <= prev_keys_nxt;
    out_r       <= out_nxt;
  end

  // sequencer
  always_comb begin
    logic [CW-1:0]  n_after;
    logic           room;
    logic [IW+3:0]  grow;
    logic [IW-1:0]  jh;
    logic [2:0]     cd;
    rps_pkg::keys_t ok;

    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    live_nxt      = live_r;
    h_nxt         = h_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    dims_nxt      = dims_r;
    held_nxt      = held_r;
    prev_keys_nxt = prev_keys_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    in_ready      = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = '0;
    mem_raddr     = '0;
    mem_wdata     = {in_keys_p, VALUE_BITS'(in_data.row_value),
                     in_data.is_deleted, in_data.is_marked};
    room          = (cnt_r < CW'(MAX_ROWS));
    n_after       = cnt_r + CW'(room);
    grow          = (IW+4)'(h_r) * (IW+4)'(9) + (IW+4)'(4);
    jh            = j_r - IW'(h_r);
    cd            = '0;
    ok            = '0;

    case (state_r)
      // take rows into the store
      rps_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (room) begin
            mem_we    = 1'b1;
            mem_waddr = AW'(cnt_r);
            cnt_nxt   = n_after;
            live_nxt  = live_r + CW'(!in_data.is_deleted);
          end
          if (in_data.last_row) begin
            dims_nxt = dims_clamp;
            h_nxt    = CW'(1);
            k_nxt    = '0;
            if (n_after != '0) begin
              state_nxt = rps_pkg::ST_GAP;
            end
          end
        end
      end
      // grow the starting gap
      rps_pkg::ST_GAP: begin
        if (grow < (IW+4)'(cnt_r)) begin
          h_nxt = CW'(3 * h_r + 1);
        end else begin
          i_nxt     = IW'(h_r) + IW'(1);
          state_nxt = rps_pkg::ST_PASS;
        end
      end
      // next insertion of this pass, next gap, or emission once the gaps are done
      rps_pkg::ST_PASS: begin
        if (h_r == '0) begin
          state_nxt = rps_pkg::ST_EMIT_RD;
        end else if (i_r > IW'(cnt_r)) begin
          h_nxt = h_div3;
          i_nxt = IW'(h_div3) + IW'(1);
        end else begin
          state_nxt = rps_pkg::ST_SAVE_RD;
        end
      end
      rps_pkg::ST_SAVE_RD: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(i_r - IW'(1));
        state_nxt = rps_pkg::ST_SAVE_WT;
      end
      rps_pkg::ST_SAVE_WT: begin
        held_nxt  = mem_rdata;
        j_nxt     = i_r;
        state_nxt = rps_pkg::ST_TEST;
      end
      // fetch the row one gap below, if there is one
      rps_pkg::ST_TEST: begin
        if (IW'(h_r) < j_r) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(jh - IW'(1));
          state_nxt = rps_pkg::ST_CMP;
        end else begin
          state_nxt = rps_pkg::ST_PUT;
        end
      end
      // shift it up if the held row goes first
      rps_pkg::ST_CMP: begin
        if (held_first) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(j_r - IW'(1));
          mem_wdata = mem_rdata;
          j_nxt     = jh;
          state_nxt = rps_pkg::ST_TEST;
        end else begin
          state_nxt = rps_pkg::ST_PUT;
        end
      end
      rps_pkg::ST_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(j_r - IW'(1));
        mem_wdata = held_r;
        i_nxt     = i_r + IW'(1);
        state_nxt = rps_pkg::ST_PASS;
      end
      // emission of live rows in order
      rps_pkg::ST_EMIT_RD: begin
        if (k_r == live_r) begin
          cnt_nxt   = '0;
          live_nxt  = '0;
          state_nxt = rps_pkg::ST_LOAD;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = AW'(k_r);
          state_nxt = rps_pkg::ST_EMIT_WT;
        end
      end
      rps_pkg::ST_EMIT_WT: begin
        for (int d = 0; d < MAX_DIMS; d++) begin
          if (4'(d) < dims_r) begin
            ok[d] = rd_keys[d];
          end
          if (d >= 2 && 4'(d) < dims_r && rd_keys[d] != prev_keys_r[d]) begin
            cd = 3'(d);
          end
        end
        if (k_r == '0) begin
          cd = 3'(dims_r - 4'd1);
        end
        out_nxt.out_value  = 64'(rd_value);
        out_nxt.out_key_0  = ok[0];
        out_nxt.out_key_1  = ok[1];
        out_nxt.out_key_2  = ok[2];
        out_nxt.out_key_3  = ok[3];
        out_nxt.out_key_4  = ok[4];
        out_nxt.out_key_5  = ok[5];
        out_nxt.out_key_6  = ok[6];
        out_nxt.out_key_7  = ok[7];
        out_nxt.out_marked = mem_rdata[0];
        out_nxt.change_dim = cd;
        out_nxt.last_out   = (k_r + CW'(1) == live_r);
        prev_keys_nxt      = rd_keys;
        out_valid_nxt      = 1'b1;
        state_nxt          = rps_pkg::ST_EMIT_HOLD;
      end
      rps_pkg::ST_EMIT_HOLD: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          k_nxt         = k_r + CW'(1);
          state_nxt     = rps_pkg::ST_EMIT_RD;
        end
      end
      default: begin
        state_nxt = rps_pkg::ST_LOAD;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // checks
  a_no_load_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid)
    else $error("input taken while an item is pending");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_ROWS))
    else $error("row count beyond capacity");

  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= cnt_r)
    else $error("live count above row count");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.last_out |=> ##1 in_ready)
    else $error("block not back to load after final item");

endmodule
`default_nettype wire

// ===== test/row_page_shell_sorter_check.sv =====
// Checker of the row page sorter: watches both channels, sorts each page, compares results.
`default_nettype none
module row_page_shell_sorter_check (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire rps_pkg::in_item_t  in_data,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire rps_pkg::out_item_t out_data,
  input  wire logic               cfg_we,
  input  wire logic [3:0]         cfg_data,
  output int                      fail_count,
  output int                      pending_rows,
  output int                      rows_seen
);

  localparam int PAGE_ROWS = 64;

  typedef struct {
    logic [63:0]    value;
    rps_pkg::keys_t keys;
    logic           marked;
    logic           deleted;
  } row_t;

  row_t               page_rows[PAGE_ROWS];
  int                 page_fill;
  logic [3:0]         dims_reg;
  rps_pkg::out_item_t sorted_rows[$];

  // live before deleted, then keys from the top dimension down
  function automatic bit row_precedes(row_t a, row_t b, int dims);
    if (a.deleted) return 0;
    if (b.deleted) return 1;
    for (int d = dims - 1; d >= 0; d--) begin
      if (a.keys[d] < b.keys[d]) return 1;
      if (a.keys[d] > b.keys[d]) return 0;
    end
    return 0;
  endfunction

  // Knuth-gap Shell sort of the page, then queue the live rows
  task automatic sort_page();
    int   h, j, dims, live;
    row_t held;
    rps_pkg::out_item_t o;
    h = 1;
    dims = (dims_reg < 1) ? 1 : ((dims_reg > 8) ? 8 : int'(dims_reg));
    while (9 * h + 4 < page_fill) h = 3 * h + 1;
    while (h > 0) begin
      for (int i = h; i < page_fill; i++) begin
        held = page_rows[i];
        j = i;
        while (j >= h && row_precedes(held, page_rows[j - h], dims)) begin
          page_rows[j] = page_rows[j - h];
          j -= h;
        end
        page_rows[j] = held;
      end
      h /= 3;
    end
    live = 0;
    while (live < page_fill && !page_rows[live].deleted) live++;
    for (int k = 0; k < live; k++) begin
      rps_pkg::keys_t kk;
      kk = '0;
      for (int d = 0; d < dims; d++) kk[d] = page_rows[k].keys[d];
      o = '0;
      o.out_value = page_rows[k].value;
      {o.out_key_7, o.out_key_6, o.out_key_5, o.out_key_4,
       o.out_key_3, o.out_key_2, o.out_key_1, o.out_key_0} = kk;
      o.out_marked = page_rows[k].marked;
      if (k == 0) o.change_dim = 3'(dims - 1);
      else begin
        o.change_dim = 0;
        for (int d = dims - 1; d >= 2; d--)
          if (page_rows[k].keys[d] != page_rows[k - 1].keys[d]) begin
            o.change_dim = 3'(d);
            break;
          end
      end
      o.last_out = (k + 1 == live);
      sorted_rows.push_back(o);
    end
    page_fill = 0;
  endtask

  assign pending_rows = sorted_rows.size();

  always @(posedge clk) begin
    rps_pkg::out_item_t want;
    if (!rst_n) begin
      page_fill = 0;
      dims_reg <= rps_pkg::DIMS_RESET;
      fail_count <= 0;
      rows_seen <= 0;
    end else begin
      if (cfg_we) dims_reg <= cfg_data;
      // result side first: a page's results cannot show in its last-row cycle
      if (out_valid && out_ready) begin
        rows_seen <= rows_seen + 1;
        if (sorted_rows.size() == 0) begin
          $display("%0t unexpected row: expected none, actual %h", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = sorted_rows.pop_front();
          if (want !== out_data) begin
            $display("%0t row mismatch: expected %h, actual %h", $time, want, out_data);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (page_fill < PAGE_ROWS) begin
          page_rows[page_fill].value   = in_data.row_value;
          page_rows[page_fill].keys    = rps_pkg::in_keys(in_data);
          page_rows[page_fill].marked  = in_data.is_marked;
          page_rows[page_fill].deleted = in_data.is_deleted;
          page_fill++;
        end
        if (in_data.last_row) sort_page();
      end
    end
  end
endmodule
`default_nettype wire

// ===== test/row_page_shell_sorter_test.sv =====
// Testbench top of the row page sorter: stimulus, idling, watchdog and verdict.
`default_nettype none
module row_page_shell_sorter_test;

  localparam int STALL_LIMIT = 20000;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_ready;
  rps_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 0;
  rps_pkg::out_item_t out_data;
  logic               cfg_we = 0;
  logic [3:0]         cfg_data = '0;
  int                 fail_count, pending_rows, rows_seen;
  int                 items_sent = 0;
  int                 pages_sent = 0;
  int                 idle_cycles = 0;
  bit                 calm = 0;

  row_page_shell_sorter u_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data, .cfg_we, .cfg_data
  );

  row_page_shell_sorter_check u_check (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .cfg_we, .cfg_data, .fail_count, .pending_rows, .rows_seen
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // receiver stalls in random bursts, except when calm or in reset
  always @(posedge clk) begin
    int burst;
    if (calm || !rst_n) begin
      burst = 0;
      out_ready <= 1;
    end else if (burst > 0) begin
      burst--;
      out_ready <= 0;
    end else if ($urandom_range(0, 5) == 0) begin
      burst = $urandom_range(1, 6) - 1;
      out_ready <= 0;
    end else begin
      out_ready <= 1;
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [31:0] pick_key(int mode);
    case (mode)
      0: return $urandom_range(0, 3);
      1: return 32'hffffffff - $urandom_range(0, 1);
      2: return {2'b11, 30'h3fffffff} & $urandom;
      default: return $urandom;
    endcase
  endfunction

  // valid stays up between back-to-back items and drops only for a gap
  task automatic send_row(rps_pkg::in_item_t it);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // one page of n rows; key modes small, tie-heavy or full range
  task automatic send_page(int n, int mode, int del_pct);
    rps_pkg::in_item_t it;
    for (int r = 0; r < n; r++) begin
      it.row_value = {$urandom, $urandom};
      it.key_0 = pick_key(mode); it.key_1 = pick_key(mode);
      it.key_2 = pick_key(mode); it.key_3 = pick_key(mode);
      it.key_4 = pick_key(mode); it.key_5 = pick_key(mode);
      it.key_6 = pick_key(mode); it.key_7 = pick_key(mode);
      it.is_marked = $urandom_range(0, 1);
      it.is_deleted = ($urandom_range(0, 99) < del_pct);
      it.last_row = (r == n - 1);
      send_row(it);
    end
    pages_sent++;
  endtask

  // wait until the block is idle and back in load, then write dims
  task automatic drain_and_set(logic [3:0] dims);
    in_valid <= 0;
    @(posedge clk);
    while (pending_rows != 0) @(posedge clk);
    while (!in_ready) @(posedge clk);
    repeat (5) @(posedge clk);
    cfg_we <= 1;
    cfg_data <= dims;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  initial begin
    rps_pkg::in_item_t it;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes, single row, all deleted, ties, reset dims
    it = '1;
    send_row(it);
    it = '0; it.last_row = 1;
    send_row(it);
    send_page(1, 3, 0);
    send_page(3, 0, 100);
    send_page(4, 0, 30);
    drain_and_set(4'd0);
    send_page(5, 1, 20);
    drain_and_set(4'd15);
    send_page(6, 2, 0);
    drain_and_set(4'd8);
    // overflow page: beyond capacity rows ignored, last one still sorts
    send_page(66, 0, 10);
    drain_and_set(4'd1);
    send_page(4, 3, 0);

    // random pages with random dims
    while (items_sent < 140) begin
      drain_and_set(4'($urandom_range(0, 15)));
      if (items_sent > 110) calm = 1;
      send_page($urandom_range(1, 14), $urandom_range(0, 3), $urandom_range(0, 40));
    end
    calm = 1;
    drain_and_set(4'd3);
    send_page(64, 3, 5);
    in_valid <= 0;

    @(posedge clk);
    while (pending_rows != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d rows in %0d pages, %0d sorted rows checked",
             items_sent, pages_sent, rows_seen);
    if (fail_count == 0 && pending_rows == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
sv/rps_pkg.sv
sv/rps_row_mem.sv
sv/rps_row_cmp.sv
sv/row_page_shell_sorter.sv
test/row_page_shell_sorter_check.sv
test/row_page_shell_sorter_test.sv
